[sv/ura_pkg.sv]
// shared types and constants for the upload ring allocator
// no dependencies; used by ura_controller, ura_datapath and upload_ring_allocator
package ura_pkg;

   // default configuration
   localparam int unsigned BUFFER_BYTES_DEF = 16777216;
   localparam int unsigned SLOT_COUNT_DEF   = 16;
   localparam int unsigned ALIGN_BYTES_DEF  = 512;

   // rounded size fits here for any alignment up to 64k and a 25-bit request
   localparam int unsigned XW       = 26;
   // shift of the reciprocal used for the alignment round-up
   localparam int unsigned RECIP_SH = 27;

   // command codes
   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_SUBMIT = 2'd1;
   localparam logic [1:0] MODE_RETIRE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SLOT  = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;
   localparam logic [1:0] ST_BAD      = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [24:0] alloc_bytes;
      logic [3:0]  slot_sel;
      logic [31:0] completed_fence;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] alloc_offset;
      logic [3:0]  alloc_slot;
      logic [31:0] issued_fence;
      logic [4:0]  retired_count;
      logic [24:0] bytes_in_use;
   } rsp_type;

   typedef enum logic [3:0] {
      CTL_IDLE,
      CTL_AL_MUL,
      CTL_AL_SCALE,
      CTL_AL_ROUND,
      CTL_AL_CHECK,
      CTL_AL_PLACE,
      CTL_SUBMIT,
      CTL_RT_CHECK,
      CTL_RT_ADV,
      CTL_BAD
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       alloc_commit;
      logic       submit_commit;
      logic       retire_pad;
      logic       retire_size;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic size_bad;
      logic ring_full;
      logic space_bad;
      logic place_ok;
      logic submit_bad;
      logic walk_go;
   } dp_stat_type;

endpackage

[sv/ura_controller.sv]
// command sequencer of the upload ring allocator
// depends on ura_pkg; drives ura_datapath through ctl_cmd_type
module ura_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_mode,
   input  ura_pkg::dp_stat_type stat,
   output logic                 busy,
   output logic                 rsp_strobe,
   output ura_pkg::ctl_cmd_type cmd
);

   ura_pkg::ctl_state_type state_ff, state_in;
   logic                   strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ura_pkg::CTL_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ura_pkg::CTL_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               case (req_mode)
                  ura_pkg::MODE_ALLOC:  state_in = ura_pkg::CTL_AL_MUL;
                  ura_pkg::MODE_SUBMIT: state_in = ura_pkg::CTL_SUBMIT;
                  ura_pkg::MODE_RETIRE: state_in = ura_pkg::CTL_RT_CHECK;
                  default:              state_in = ura_pkg::CTL_BAD;
               endcase
            end
         end
         ura_pkg::CTL_AL_MUL:   state_in = ura_pkg::CTL_AL_SCALE;
         ura_pkg::CTL_AL_SCALE: state_in = ura_pkg::CTL_AL_ROUND;
         ura_pkg::CTL_AL_ROUND: state_in = ura_pkg::CTL_AL_CHECK;
         ura_pkg::CTL_AL_CHECK: begin
            // size, then ring, then space
            if (stat.size_bad) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ura_pkg::ST_BAD;
               state_in       = ura_pkg::CTL_IDLE;
            end else if (stat.ring_full) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ura_pkg::ST_NO_SLOT;
               state_in       = ura_pkg::CTL_IDLE;
            end else if (stat.space_bad) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ura_pkg::ST_NO_SPACE;
               state_in       = ura_pkg::CTL_IDLE;
            end else begin
               state_in = ura_pkg::CTL_AL_PLACE;
            end
         end
         ura_pkg::CTL_AL_PLACE: begin
            cmd.rsp_load = 1'b1;
            if (stat.place_ok) begin
               cmd.alloc_commit = 1'b1;
               cmd.rsp_status   = ura_pkg::ST_OK;
            end else begin
               cmd.rsp_status = ura_pkg::ST_NO_SPACE;
            end
            state_in = ura_pkg::CTL_IDLE;
         end
         ura_pkg::CTL_SUBMIT: begin
            cmd.rsp_load = 1'b1;
            if (stat.submit_bad) begin
               cmd.rsp_status = ura_pkg::ST_BAD;
            end else begin
               cmd.submit_commit = 1'b1;
               cmd.rsp_status    = ura_pkg::ST_OK;
            end
            state_in = ura_pkg::CTL_IDLE;
         end
         ura_pkg::CTL_RT_CHECK: begin
            if (stat.walk_go) begin
               cmd.retire_pad = 1'b1;
               state_in       = ura_pkg::CTL_RT_ADV;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ura_pkg::ST_OK;
               state_in       = ura_pkg::CTL_IDLE;
            end
         end
         ura_pkg::CTL_RT_ADV: begin
            cmd.retire_size = 1'b1;
            state_in        = ura_pkg::CTL_RT_CHECK;
         end
         ura_pkg::CTL_BAD: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = ura_pkg::ST_BAD;
            state_in       = ura_pkg::CTL_IDLE;
         end
         default: state_in = ura_pkg::CTL_IDLE;
      endcase
   end

   assign strobe_in  = cmd.rsp_load;
   assign busy       = (state_ff != ura_pkg::CTL_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

[sv/ura_datapath.sv]
// ring state, slot storage, round-up arithmetic and response register
// depends on ura_pkg; sequenced by ura_controller
module ura_datapath #(
   parameter int unsigned BUFFER_BYTES = ura_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned SLOT_COUNT   = ura_pkg::SLOT_COUNT_DEF,
   parameter int unsigned ALIGN_BYTES  = ura_pkg::ALIGN_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ura_pkg::req_type     req_data,
   input  ura_pkg::ctl_cmd_type cmd,
   output ura_pkg::dp_stat_type stat,
   output ura_pkg::rsp_type     rsp_data
);

   localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
   localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int unsigned RW      = $clog2(BUFFER_BYTES) + 1;
   localparam int unsigned XW      = ura_pkg::XW;
   localparam int unsigned CW      = ((RW > XW) ? RW : XW) + 1;
   localparam int unsigned AW      = $clog2(ALIGN_BYTES + 1);
   localparam int unsigned RECIP_W = ura_pkg::RECIP_SH + 1;
   localparam int unsigned RECIP   = (2 ** ura_pkg::RECIP_SH) / ALIGN_BYTES;
   localparam int unsigned MW      = XW + RECIP_W;
   localparam int unsigned PW      = XW + AW;

   localparam logic [CW-1:0] BUF_C   = CW'(BUFFER_BYTES);
   localparam logic [XW-1:0] ALIGN_X = XW'(ALIGN_BYTES);

   // captured transaction and round-up pipeline
   ura_pkg::req_type req_ff;
   logic [XW-1:0]    x_ff, q_ff, prod_ff, size_ff;
   logic [XW-1:0]    x_in, q_in, prod_in, size_in, rem, rem_fix;
   logic [MW-1:0]    mul_full;
   logic [PW-1:0]    prod_full;

   // ring state
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      slots_ff, slots_in;
   logic [RW-1:0]         start_ff, start_in;
   logic [RW-1:0]         used_ff, used_in;
   logic [31:0]           fence_ff, fence_in, fence_next;
   logic [SLOT_COUNT-1:0] alloc_ff, alloc_in;
   logic [SLOT_COUNT-1:0] sub_ff, sub_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CW-1:0]         end_ff;

   // slot storage
   logic [2*RW-1:0] sp_mem [SLOT_COUNT];
   logic [31:0]     fence_mem [SLOT_COUNT];
   logic [2*RW-1:0] sp_rd_ff;
   logic [31:0]     fence_rd_ff;
   logic [RW-1:0]   rd_size, rd_pad;

   // allocate placement
   logic [CW-1:0]    size_c, start_c, used_c, tail, wend, at_c, pad_c;
   logic             place_ok;
   logic [CNT_W:0]   idx_sum, idx_wrap;
   logic [IDX_W-1:0] alloc_idx, sel_idx;
   logic             sel_range;

   // retire steps
   logic [CW-1:0] s1, s1m, s2, s2m;
   logic [RW-1:0] u1, u2;

   ura_pkg::rsp_type rsp_ff, rsp_in;

   // round-up: size = x - (x mod align), x = bytes + align - 1
   assign x_in      = XW'(req_data.alloc_bytes) + XW'(ALIGN_BYTES - 1);
   assign mul_full  = MW'(x_ff) * MW'(RECIP);
   assign q_in      = XW'(mul_full >> ura_pkg::RECIP_SH);
   assign prod_full = PW'(q_ff) * PW'(ALIGN_BYTES);
   assign prod_in   = XW'(prod_full);
   assign rem       = x_ff - prod_ff;
   assign rem_fix   = (rem >= ALIGN_X) ? (rem - ALIGN_X) : rem;
   assign size_in   = x_ff - rem_fix;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         x_ff   <= x_in;
      end
      q_ff    <= q_in;
      prod_ff <= prod_in;
      size_ff <= size_in;
      end_ff  <= start_c + used_c;
   end

   assign size_c  = CW'(size_ff);
   assign start_c = CW'(start_ff);
   assign used_c  = CW'(used_ff);

   assign stat.size_bad  = (size_c == '0) || (size_c > BUF_C);
   assign stat.ring_full = (slots_ff >= CNT_W'(SLOT_COUNT));
   assign stat.space_bad = (used_c > BUF_C) || (size_c > BUF_C - used_c);

   assign tail = BUF_C - end_ff;
   assign wend = end_ff - BUF_C;

   always_comb begin
      place_ok = 1'b0;
      at_c     = '0;
      pad_c    = '0;
      if (end_ff < BUF_C) begin
         if (tail >= size_c) begin
            place_ok = 1'b1;
            at_c     = end_ff;
         end else if (start_c >= size_c) begin
            // wrap to the base, tail charged as padding
            place_ok = 1'b1;
            pad_c    = tail;
         end
      end else if ((start_c >= wend) && (start_c - wend >= size_c)) begin
         place_ok = 1'b1;
         at_c     = wend;
      end
   end
   assign stat.place_ok = place_ok;

   assign idx_sum   = (CNT_W+1)'(head_ff) + (CNT_W+1)'(slots_ff);
   assign idx_wrap  = (idx_sum >= (CNT_W+1)'(SLOT_COUNT)) ?
                      (idx_sum - (CNT_W+1)'(SLOT_COUNT)) : idx_sum;
   assign alloc_idx = IDX_W'(idx_wrap);

   // submit
   assign sel_idx         = IDX_W'(req_ff.slot_sel);
   assign sel_range       = (32'(req_ff.slot_sel) < SLOT_COUNT);
   assign stat.submit_bad = !sel_range || !alloc_ff[sel_idx] || sub_ff[sel_idx];
   assign fence_next      = fence_ff + 32'd1;

   // retire: head entry is always in the read registers
   assign rd_size      = sp_rd_ff[2*RW-1:RW];
   assign rd_pad       = sp_rd_ff[RW-1:0];
   assign stat.walk_go = (slots_ff != '0) && sub_ff[head_ff] &&
                         (fence_rd_ff <= req_ff.completed_fence);

   assign s1  = start_c + CW'(rd_pad);
   assign s1m = (s1 >= BUF_C) ? (s1 - BUF_C) : s1;
   assign u1  = (used_ff >= rd_pad) ? (used_ff - rd_pad) : '0;
   assign s2  = start_c + CW'(rd_size);
   assign s2m = (s2 >= BUF_C) ? (s2 - BUF_C) : s2;
   assign u2  = (used_ff >= rd_size) ? (used_ff - rd_size) : '0;

   always_comb begin
      head_in  = head_ff;
      slots_in = slots_ff;
      start_in = start_ff;
      used_in  = used_ff;
      fence_in = fence_ff;
      alloc_in = alloc_ff;
      sub_in   = sub_ff;
      count_in = count_ff;
      if (cmd.load_req) begin
         count_in = '0;
      end
      if (cmd.alloc_commit) begin
         slots_in            = slots_ff + CNT_W'(1);
         used_in             = RW'(used_c + size_c + pad_c);
         alloc_in[alloc_idx] = 1'b1;
         sub_in[alloc_idx]   = 1'b0;
      end
      if (cmd.submit_commit) begin
         fence_in        = fence_next;
         sub_in[sel_idx] = 1'b1;
      end
      if (cmd.retire_pad) begin
         start_in          = RW'(s1m);
         used_in           = u1;
         alloc_in[head_ff] = 1'b0;
         sub_in[head_ff]   = 1'b0;
      end
      if (cmd.retire_size) begin
         used_in  = u2;
         start_in = (u2 == '0) ? '0 : RW'(s2m);
         head_in  = (head_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_ff + IDX_W'(1);
         slots_in = slots_ff - CNT_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         slots_ff <= '0;
         start_ff <= '0;
         used_ff  <= '0;
         fence_ff <= '0;
         alloc_ff <= '0;
         sub_ff   <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         slots_ff <= slots_in;
         start_ff <= start_in;
         used_ff  <= used_in;
         fence_ff <= fence_in;
         alloc_ff <= alloc_in;
         sub_ff   <= sub_in;
         count_ff <= count_in;
      end
   end

   // slot memories, read at the next head so the data tracks head_ff
   always_ff @(posedge clock) begin
      if (cmd.alloc_commit) begin
         sp_mem[alloc_idx] <= {RW'(size_c), RW'(pad_c)};
      end
      if (cmd.submit_commit) begin
         fence_mem[sel_idx] <= fence_next;
      end
      sp_rd_ff    <= sp_mem[head_in];
      fence_rd_ff <= fence_mem[head_in];
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = cmd.rsp_status;
      rsp_in.bytes_in_use  = 25'(used_in);
      if (cmd.alloc_commit) begin
         rsp_in.alloc_offset = 24'(at_c);
         rsp_in.alloc_slot   = 4'(alloc_idx);
      end
      if (cmd.submit_commit) begin
         rsp_in.issued_fence = fence_next;
      end
      if (req_ff.mode == ura_pkg::MODE_RETIRE) begin
         rsp_in.retired_count = 5'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[sv/upload_ring_allocator.sv]
// top level of the upload ring allocator: ring of submission slots over a byte buffer
// depends on ura_pkg, ura_controller and ura_datapath
//
//   channel   | ports                       | handshake
//   ----------+-----------------------------+------------------------------------
//   request   | start, busy, req_data       | taken when start is high, busy low
//   response  | rsp_strobe, rsp_data        | one cycle, one strobe per request
//
// sequence: allocate steps through reciprocal multiply, scale, round,
//   checks and placement, and ends after the checks when the size, ring or
//   space check rejects it; submit and bad requests answer from CTL_SUBMIT
//   and CTL_BAD; retire takes a pad step and a size step of the head slot per freed slot
// the response strobes in the first cycle busy is low again, so a new
//   transaction can be taken in that same cycle
// reset clears the ring, slot flags and fence counter at once, no sweep
// the receiver cannot stall; a response is never held
module upload_ring_allocator #(
   parameter int unsigned BUFFER_BYTES = ura_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned SLOT_COUNT   = ura_pkg::SLOT_COUNT_DEF,
   parameter int unsigned ALIGN_BYTES  = ura_pkg::ALIGN_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ura_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ura_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   ura_pkg::ctl_cmd_type cmd;
   ura_pkg::dp_stat_type stat;

   // sequencer: decodes the mode and steps the allocate and retire walks
   ura_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_mode   (req_data.mode),
      .stat       (stat),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // datapath: ring registers, slot memories and response register
   ura_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .SLOT_COUNT   (SLOT_COUNT),
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

[dv/tb_top.sv]
// self-checking bench for upload_ring_allocator: directed corner transactions, then random traffic
// depends on ura_pkg and the upload_ring_allocator rtl; predicts each response in-line
module tb_top;
   import ura_pkg::*;

   localparam longint BUF_BYTES   = longint'(BUFFER_BYTES_DEF);
   localparam longint ALIGN       = longint'(ALIGN_BYTES_DEF);
   localparam int     NUM_SLOTS   = int'(SLOT_COUNT_DEF);
   localparam int     RANDOM_CNT  = 1000;
   localparam int     DRAIN_AT    = 520;
   localparam int     TAIL_CYCLES = 48;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     SHOW_MAX    = 10;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // dut
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   upload_ring_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // shadow of the allocator state
   int          ring_head;
   int          ring_count;
   longint      win_start;
   longint      win_used;
   logic [31:0] fence_count;
   longint      blk_size  [NUM_SLOTS];
   longint      blk_pad   [NUM_SLOTS];
   logic [31:0] blk_fence [NUM_SLOTS];
   bit          blk_sub   [NUM_SLOTS];

   initial begin
      ring_head   = 0;
      ring_count  = 0;
      win_start   = 0;
      win_used    = 0;
      fence_count = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         blk_size[i]  = 0;
         blk_pad[i]   = 0;
         blk_fence[i] = '0;
         blk_sub[i]   = 1'b0;
      end
   end

   // response a transaction produces; updates the shadow state as a side effect
   function automatic rsp_type predict_response(req_type rq);
      rsp_type     r;
      longint      size;
      longint      endp;
      longint      wend;
      longint      tail_len;
      longint      at;
      longint      pad;
      longint      freed;
      bit          placed;
      int          idx;
      int          freed_cnt;
      r = '0;
      case (rq.mode)
         MODE_ALLOC: begin
            size   = ((longint'(rq.alloc_bytes) + ALIGN - 1) / ALIGN) * ALIGN;
            placed = 1'b0;
            at     = 0;
            pad    = 0;
            if (size == 0 || size > BUF_BYTES) begin
               r.status = ST_BAD;
            end else if (ring_count >= NUM_SLOTS) begin
               // ring full wins over a space shortage
               r.status = ST_NO_SLOT;
            end else if (win_used > BUF_BYTES || size > BUF_BYTES - win_used) begin
               r.status = ST_NO_SPACE;
            end else begin
               endp = win_start + win_used;
               if (endp < BUF_BYTES) begin
                  tail_len = BUF_BYTES - endp;
                  if (tail_len >= size) begin
                     at     = endp;
                     placed = 1'b1;
                  end else if (win_start >= size) begin
                     // tail too short: wrap to zero and charge the tail as padding
                     at     = 0;
                     pad    = tail_len;
                     placed = 1'b1;
                  end
               end else begin
                  // used region already wraps, free gap sits below win_start
                  wend = endp % BUF_BYTES;
                  if (win_start >= wend && win_start - wend >= size) begin
                     at     = wend;
                     placed = 1'b1;
                  end
               end
               if (!placed) begin
                  r.status = ST_NO_SPACE;
               end else begin
                  idx             = (ring_head + ring_count) % NUM_SLOTS;
                  ring_count      = ring_count + 1;
                  win_used        = win_used + size + pad;
                  blk_size[idx]   = size;
                  blk_pad[idx]    = pad;
                  blk_sub[idx]    = 1'b0;
                  blk_fence[idx]  = '0;
                  r.status        = ST_OK;
                  r.alloc_offset  = 24'(at);
                  r.alloc_slot    = 4'(idx);
               end
            end
         end
         MODE_SUBMIT: begin
            idx = int'(rq.slot_sel);
            if (idx >= NUM_SLOTS || blk_size[idx] == 0 || blk_sub[idx]) begin
               r.status = ST_BAD;
            end else begin
               fence_count    = fence_count + 32'd1;
               blk_fence[idx] = fence_count;
               blk_sub[idx]   = 1'b1;
               r.status       = ST_OK;
               r.issued_fence = fence_count;
            end
         end
         MODE_RETIRE: begin
            freed_cnt = 0;
            // walk from the oldest slot, stop at unsubmitted or not yet signaled
            while (ring_count > 0 && blk_sub[ring_head] &&
                   blk_fence[ring_head] <= rq.completed_fence) begin
               idx            = ring_head;
               freed          = blk_size[idx] + blk_pad[idx];
               win_start      = (win_start + blk_pad[idx]) % BUF_BYTES;
               win_start      = (win_start + blk_size[idx]) % BUF_BYTES;
               win_used       = (win_used >= freed) ? win_used - freed : 0;
               blk_size[idx]  = 0;
               blk_pad[idx]   = 0;
               blk_sub[idx]   = 1'b0;
               ring_head      = (idx + 1) % NUM_SLOTS;
               ring_count     = ring_count - 1;
               if (win_used == 0) win_start = 0;
               freed_cnt++;
            end
            r.status        = ST_OK;
            r.retired_count = 5'(freed_cnt);
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      r.bytes_in_use = 25'(win_used);
      return r;
   endfunction

   // stimulus and scoreboard storage
   req_type pending_req[$];
   rsp_type expected_rsp[$];
   bit      gen_done = 1'b0;
   int      directed_cnt = 0;

   task automatic add_item(logic [1:0] m, logic [24:0] b, logic [3:0] s, logic [31:0] f);
      req_type rq;
      rq.mode            = m;
      rq.alloc_bytes     = b;
      rq.slot_sel        = s;
      rq.completed_fence = f;
      pending_req.push_back(rq);
   endtask

   // stimulus generator: directed corners first, then random traffic
   initial begin : gen_proc
      req_type     rq;
      int unsigned pick;
      int unsigned op;
      bit          fill_phase;
      int          open_slots[$];

      // unknown mode, zero and oversized allocates, submit of a free slot, retire of an empty ring
      add_item(2'd3, 25'h1FFFFFF, 4'hF, 32'hFFFFFFFF);
      add_item(MODE_ALLOC, 25'h0, 4'h0, 32'h0);
      add_item(MODE_ALLOC, 25'h1FFFFFF, 4'h0, 32'h0);
      add_item(MODE_ALLOC, 25'h1000001, 4'h0, 32'h0);
      add_item(MODE_SUBMIT, 25'h0, 4'hF, 32'h0);
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'h0);
      // whole buffer in one slot, then no space left
      add_item(MODE_ALLOC, 25'h1000000, 4'h0, 32'h0);
      add_item(MODE_ALLOC, 25'h1, 4'h0, 32'h0);
      // retire stops at an unsubmitted head
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'hFFFFFFFF);
      add_item(MODE_SUBMIT, 25'h0, 4'h0, 32'h0);
      // double submit is rejected
      add_item(MODE_SUBMIT, 25'h0, 4'h0, 32'h0);
      // fence not reached yet
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'h0);
      // buffer empties, region start back to zero
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'hFFFFFFFF);
      // build a region starting mid buffer
      add_item(MODE_ALLOC, 25'h800000, 4'h0, 32'h0);
      add_item(MODE_ALLOC, 25'h400000, 4'h0, 32'h0);
      add_item(MODE_SUBMIT, 25'h0, 4'h1, 32'h0);
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'h1);
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'h2);
      // tail too short: wrap to zero with padding, then a request just over the space left
      add_item(MODE_ALLOC, 25'h600000, 4'h0, 32'h0);
      add_item(MODE_ALLOC, 25'h200001, 4'h0, 32'h0);
      // placement inside the wrapped gap
      add_item(MODE_ALLOC, 25'h200000, 4'h0, 32'h0);
      add_item(MODE_SUBMIT, 25'h0, 4'h7, 32'h0);
      add_item(MODE_SUBMIT, 25'h0, 4'h2, 32'h0);
      add_item(MODE_SUBMIT, 25'h0, 4'h3, 32'h0);
      add_item(MODE_SUBMIT, 25'h0, 4'h4, 32'h0);
      add_item(MODE_RETIRE, 25'h0, 4'h0, 32'hFFFFFFFF);
      directed_cnt = pending_req.size();

      for (int n = 0; n < RANDOM_CNT; n++) begin
         // stay a few transactions ahead so choices follow the shadow state
         while (pending_req.size() >= 3) @(negedge clock);
         fill_phase         = (n % 200) < 40;
         rq.mode            = 2'($urandom);
         rq.alloc_bytes     = 25'($urandom);
         rq.slot_sel        = 4'($urandom);
         rq.completed_fence = $urandom;
         op = $urandom_range(0, 99);
         if (op < (fill_phase ? 80 : 45)) begin
            rq.mode = MODE_ALLOC;
            pick = $urandom_range(0, 99);
            if (fill_phase || pick < 50) rq.alloc_bytes = 25'($urandom_range(1, 65536));
            else if (pick < 78) rq.alloc_bytes = 25'($urandom_range(1, 2097152));
            else if (pick < 93) rq.alloc_bytes = 25'($urandom_range(1, 8388608));
            else if (pick < 95) rq.alloc_bytes = 25'h1000000;
            // else keep the full-range random size
         end else if (op < (fill_phase ? 90 : 77)) begin
            rq.mode = MODE_SUBMIT;
            open_slots.delete();
            for (int i = 0; i < NUM_SLOTS; i++)
               if (blk_size[i] != 0 && !blk_sub[i]) open_slots.push_back(i);
            if (open_slots.size() != 0 && $urandom_range(0, 99) < 85)
               rq.slot_sel = 4'(open_slots[$urandom_range(0, open_slots.size() - 1)]);
         end else if (op < 96) begin
            rq.mode = MODE_RETIRE;
            pick = $urandom_range(0, 99);
            if (pick < 65) rq.completed_fence = fence_count - 32'($urandom_range(0, 4));
            else if (pick < 80) rq.completed_fence = 32'hFFFFFFFF;
            // else keep a random fence
         end else begin
            rq.mode = 2'd3;
         end
         pending_req.push_back(rq);
      end
      gen_done = 1'b1;
   end

   // driver: bursts with random gaps, two pauses until all responses are back
   int accepted_cnt = 0;
   int rsp_cnt      = 0;
   int issued_cnt   = 0;
   int burst_left   = 0;
   int gap_left     = 0;

   always @(posedge clock) begin : drive_proc
      bit fire;
      bit hold_for_drain;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            expected_rsp.push_back(predict_response(req_data));
            accepted_cnt++;
         end
         // pause after the directed part and once mid run until the dut is empty
         hold_for_drain = (issued_cnt == directed_cnt || issued_cnt == DRAIN_AT) &&
                          accepted_cnt != rsp_cnt;
         if (start && !fire) begin
            // busy: keep the transaction on the bus
         end else if (pending_req.size() != 0 && gap_left == 0 && !hold_for_drain) begin
            start    <= 1'b1;
            req_data <= pending_req.pop_front();
            issued_cnt++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // monitor: every strobe is checked against the oldest prediction
   int fail_cnt = 0;

   always @(posedge clock) begin : mon_proc
      rsp_type want;
      if (!reset && rsp_strobe) begin
         rsp_cnt <= rsp_cnt + 1;
         if (expected_rsp.size() == 0) begin
            if (fail_cnt < SHOW_MAX)
               $display("unexpected response: st=%0d off=%h slot=%0d fence=%h cnt=%0d used=%h",
                        rsp_data.status, rsp_data.alloc_offset, rsp_data.alloc_slot,
                        rsp_data.issued_fence, rsp_data.retired_count,
                        rsp_data.bytes_in_use);
            fail_cnt++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.alloc_offset !== want.alloc_offset ||
                rsp_data.alloc_slot !== want.alloc_slot ||
                rsp_data.issued_fence !== want.issued_fence ||
                rsp_data.retired_count !== want.retired_count ||
                rsp_data.bytes_in_use !== want.bytes_in_use) begin
               if (fail_cnt < SHOW_MAX) begin
                  $display("mismatch: exp st=%0d off=%h slot=%0d fence=%h cnt=%0d used=%h",
                           want.status, want.alloc_offset, want.alloc_slot,
                           want.issued_fence, want.retired_count, want.bytes_in_use);
                  $display("          got st=%0d off=%h slot=%0d fence=%h cnt=%0d used=%h",
                           rsp_data.status, rsp_data.alloc_offset, rsp_data.alloc_slot,
                           rsp_data.issued_fence, rsp_data.retired_count,
                           rsp_data.bytes_in_use);
               end
               fail_cnt++;
            end
         end
      end
   end

   // watchdog
   int cycle_cnt = 0;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // end of run: all stimulus taken, all responses back, then a quiet tail
   initial begin
      wait (gen_done);
      while (pending_req.size() != 0 || start || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_cnt == 0 && expected_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
sv/ura_pkg.sv
sv/ura_controller.sv
sv/ura_datapath.sv
sv/upload_ring_allocator.sv
dv/tb_top.sv
